>>> rtl/pcp_pkg.sv
// ----------------------------------------------------------------------------
// pcp_pkg: shared definitions for the portal column projection
// Widths, pipeline depths, register indexes and the structs that travel
// between the front end, the divider chains and the top level.
// ----------------------------------------------------------------------------
package pcp_pkg;

  localparam int DEF_MAX_WIDTH = 4096;
  localparam int DEF_FRAC_BITS = 16;

  // rotated coordinate width, magnitude width, focal width
  localparam int CW    = 36;
  localparam int MAGW  = 35;
  localparam int FOCW  = 31;
  localparam int WW    = 13;
  localparam int COLW  = 12;
  // numerator width, quotient bits (one cell each), remainder width
  localparam int NW    = MAGW + FOCW;
  localparam int QB    = 46;
  localparam int RW    = 53;
  localparam int QW    = QB + 2;

  localparam int FRONT_DEPTH = 6;
  localparam int BACK_DEPTH  = 3;
  localparam int PIPE_DEPTH  = FRONT_DEPTH + QB + BACK_DEPTH;

  // register indexes (byte address / 4)
  localparam logic [2:0] REG_CAMERA_X = 3'd0;
  localparam logic [2:0] REG_CAMERA_Y = 3'd1;
  localparam logic [2:0] REG_COS      = 3'd2;
  localparam logic [2:0] REG_SIN      = 3'd3;
  localparam logic [2:0] REG_FOCAL    = 3'd4;
  localparam logic [2:0] REG_WIDTH    = 3'd5;

  typedef struct packed {
    logic signed [31:0] cam_x;
    logic signed [31:0] cam_y;
    logic signed [17:0] cos_v;
    logic signed [17:0] sin_v;
    logic [FOCW-1:0]    focal;
    logic [WW-1:0]      width;
  } cfg_t;

  // per-item sideband that rides alongside the arithmetic
  typedef struct packed {
    logic            inv;
    logic [WW-1:0]   width;
    logic [COLW-1:0] pmin;
    logic [COLW-1:0] pmax;
  } side_t;

endpackage

>>> rtl/portal_column_projection.sv
// ----------------------------------------------------------------------------
// portal_column_projection: wall segment to screen column range
// Translates and rotates a portal segment into camera space, projects both
// endpoints through a pair of division chains and clips the column range.
// ----------------------------------------------------------------------------
//   channel   signals                              direction
//   config    psel penable pwrite paddr pwdata     in  (prdata, pready out)
//   item      start end_* portal_enabled parent_*  in  (busy out)
//   result    done visible col_min col_max         out
//
// One item may be accepted every cycle; each item passes through 6 front
// stages, one division cell per quotient bit (46) and 3 finishing stages,
// PIPE_DEPTH in all. busy is high only during reset, which empties the
// pipeline. The receiver cannot stall; each result shows for one cycle.
module portal_column_projection import pcp_pkg::*; #(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH,
  parameter int FRAC_BITS = DEF_FRAC_BITS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] end_a_x,
  input  logic signed [31:0] end_a_y,
  input  logic signed [31:0] end_b_x,
  input  logic signed [31:0] end_b_y,
  input  logic               portal_enabled,
  input  logic [COLW-1:0]    parent_col_min,
  input  logic [COLW-1:0]    parent_col_max,
  output logic               done,
  output logic               visible,
  output logic [COLW-1:0]    col_min,
  output logic [COLW-1:0]    col_max
);

  localparam int TWA = $bits(side_t) + 1;

  cfg_t          cfg;
  logic          wr_en;

  logic          f_vld;
  side_t         f_side;
  logic          f_sg_a, f_sg_b;
  logic [RW-1:0] f_rem_a, f_rem_b, f_d_a, f_d_b;
  logic [QB-1:0] f_num_a, f_num_b;

  logic          c_vld_a, c_vld_b;
  logic [QB-1:0] c_q_a, c_q_b;
  logic [RW-1:0] c_rem_a, c_rem_b, c_d_a, c_d_b;
  logic [TWA-1:0] c_tag_a;
  logic [0:0]    c_tag_b;
  side_t         c_side;
  logic          c_sg_a;

  // finishing stages
  logic                 p1_vld, p2_vld;
  side_t                p1_side, p2_side;
  logic signed [QW-1:0] p1_q_a, p1_q_b;
  logic [RW-1:0]        p1_r_a, p1_r_b, p1_d_a, p1_d_b;
  logic signed [QW-1:0] qpos_a, qpos_b;
  logic signed [QW-1:0] fl_a, ce_a, fl_b, ce_b;
  logic signed [QW-1:0] p2_lo, p2_hi;
  logic signed [QW-1:0] lo0, lo1, hi0, hi1, wq;

  assign pready = 1'b1;
  assign busy   = rst;
  assign wr_en  = psel & penable & pwrite;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.cam_x <= '0;
      cfg.cam_y <= '0;
      cfg.cos_v <= 18'sd65536;
      cfg.sin_v <= '0;
      cfg.focal <= FOCW'(20971520);
      cfg.width <= WW'(320);
    end else if (wr_en) begin
      unique case (paddr[4:2])
        REG_CAMERA_X: cfg.cam_x <= pwdata;
        REG_CAMERA_Y: cfg.cam_y <= pwdata;
        REG_COS:      cfg.cos_v <= pwdata[17:0];
        REG_SIN:      cfg.sin_v <= pwdata[17:0];
        REG_FOCAL:    cfg.focal <= pwdata[FOCW-1:0];
        REG_WIDTH:    cfg.width <= pwdata[WW-1:0];
        default: ;
      endcase
    end
  end

  // register read back
  always_comb begin
    unique case (paddr[4:2])
      REG_CAMERA_X: prdata = cfg.cam_x;
      REG_CAMERA_Y: prdata = cfg.cam_y;
      REG_COS:      prdata = {14'b0, cfg.cos_v};
      REG_SIN:      prdata = {14'b0, cfg.sin_v};
      REG_FOCAL:    prdata = {1'b0, cfg.focal};
      REG_WIDTH:    prdata = {19'b0, cfg.width};
      default:      prdata = '0;
    endcase
  end

  pcp_front #(.MAX_WIDTH(MAX_WIDTH), .FRAC_BITS(FRAC_BITS)) u_front (
    .clk      (clk),
    .rst      (rst),
    .vld_i    (start & ~busy),
    .cfg      (cfg),
    .ax_i     (end_a_x),
    .ay_i     (end_a_y),
    .bx_i     (end_b_x),
    .by_i     (end_b_y),
    .en_i     (portal_enabled),
    .pmin_i   (parent_col_min),
    .pmax_i   (parent_col_max),
    .vld_o    (f_vld),
    .side_o   (f_side),
    .sign_a_o (f_sg_a),
    .sign_b_o (f_sg_b),
    .rem_a_o  (f_rem_a),
    .rem_b_o  (f_rem_b),
    .num_a_o  (f_num_a),
    .num_b_o  (f_num_b),
    .d_a_o    (f_d_a),
    .d_b_o    (f_d_b)
  );

  pcp_div_chain #(.TW(TWA)) u_chain_a (
    .clk   (clk),
    .rst   (rst),
    .vld_i (f_vld),
    .rem_i (f_rem_a),
    .num_i (f_num_a),
    .d_i   (f_d_a),
    .tag_i ({f_side, f_sg_a}),
    .vld_o (c_vld_a),
    .q_o   (c_q_a),
    .rem_o (c_rem_a),
    .d_o   (c_d_a),
    .tag_o (c_tag_a)
  );

  pcp_div_chain #(.TW(1)) u_chain_b (
    .clk   (clk),
    .rst   (rst),
    .vld_i (f_vld),
    .rem_i (f_rem_b),
    .num_i (f_num_b),
    .d_i   (f_d_b),
    .tag_i (f_sg_b),
    .vld_o (c_vld_b),
    .q_o   (c_q_b),
    .rem_o (c_rem_b),
    .d_o   (c_d_b),
    .tag_o (c_tag_b)
  );

  assign c_side = c_tag_a[TWA-1:1];
  assign c_sg_a = c_tag_a[0];

  // floor and ceiling of the landing point, with half a column for odd widths
  function automatic logic signed [2*QW-1:0] land(input logic signed [QW-1:0] q,
                                                   input logic [RW-1:0] r,
                                                   input logic [RW-1:0] d,
                                                   input logic [WW-1:0] w);
    logic signed [QW-1:0] base;
    logic [RW:0]          r2, d2;
    logic signed [QW-1:0] fl, ce;
    base = q + QW'(w >> 1);
    r2   = {r, 1'b0};
    d2   = {1'b0, d};
    if (!w[0]) begin
      fl = base;
      ce = base + QW'(r != '0);
    end else begin
      fl = base + QW'(r2 >= d2);
      ce = base + ((r2 > d2) ? QW'(2) : QW'(1));
    end
    return {fl, ce};
  endfunction

  assign qpos_a = QW'(c_q_a);
  assign qpos_b = QW'(c_q_b);
  assign {fl_a, ce_a} = land(p1_q_a, p1_r_a, p1_d_a, p1_side.width);
  assign {fl_b, ce_b} = land(p1_q_b, p1_r_b, p1_d_b, p1_side.width);

  // clip to screen then parent range, all compares signed
  assign wq  = QW'(p2_side.width);
  assign lo0 = (p2_lo < 0) ? '0 : p2_lo;
  assign hi0 = (p2_hi >= wq) ? (wq - QW'(1)) : p2_hi;
  assign lo1 = (lo0 < $signed(QW'(p2_side.pmin))) ? $signed(QW'(p2_side.pmin)) : lo0;
  assign hi1 = (hi0 > $signed(QW'(p2_side.pmax))) ? $signed(QW'(p2_side.pmax)) : hi0;

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_vld <= 1'b0;
      p2_vld <= 1'b0;
      done   <= 1'b0;
    end else begin
      p1_vld <= c_vld_a & c_vld_b;
      p2_vld <= p1_vld;
      done   <= p2_vld;
    end
    // signed quotient and remainder towards minus infinity
    p1_side <= c_side;
    p1_q_a  <= c_sg_a ? (-qpos_a - QW'(c_rem_a != '0)) : qpos_a;
    p1_r_a  <= (c_sg_a && c_rem_a != '0) ? (c_d_a - c_rem_a) : c_rem_a;
    p1_d_a  <= c_d_a;
    p1_q_b  <= c_tag_b[0] ? (-qpos_b - QW'(c_rem_b != '0)) : qpos_b;
    p1_r_b  <= (c_tag_b[0] && c_rem_b != '0) ? (c_d_b - c_rem_b) : c_rem_b;
    p1_d_b  <= c_d_b;

    p2_side <= p1_side;
    p2_lo   <= (fl_a < fl_b) ? fl_a : fl_b;
    p2_hi   <= (ce_a > ce_b) ? ce_a : ce_b;

    if (!p2_side.inv && lo1 <= hi1) begin
      visible <= 1'b1;
      col_min <= lo1[COLW-1:0];
      col_max <= hi1[COLW-1:0];
    end else begin
      visible <= 1'b0;
      col_min <= '0;
      col_max <= '0;
    end
  end

endmodule

>>> rtl/pcp_div_cell.sv
// ----------------------------------------------------------------------------
// pcp_div_cell: one restoring division step
// Brings in the next numerator bit, compares against the divisor, subtracts
// when it fits and shifts the quotient bit in. Registered every cycle.
// ----------------------------------------------------------------------------
module pcp_div_cell import pcp_pkg::*; #(
  parameter int TW = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          vld_i,
  input  logic [RW-1:0] rem_i,
  input  logic [QB-1:0] num_i,
  input  logic [QB-1:0] q_i,
  input  logic [RW-1:0] d_i,
  input  logic [TW-1:0] tag_i,
  output logic          vld_o,
  output logic [RW-1:0] rem_o,
  output logic [QB-1:0] num_o,
  output logic [QB-1:0] q_o,
  output logic [RW-1:0] d_o,
  output logic [TW-1:0] tag_o
);

  logic [RW-1:0] r2;
  logic          fits;

  // trial subtract
  assign r2   = {rem_i[RW-2:0], num_i[QB-1]};
  assign fits = (r2 >= d_i);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_o <= 1'b0;
    end else begin
      vld_o <= vld_i;
    end
    rem_o <= fits ? (r2 - d_i) : r2;
    num_o <= {num_i[QB-2:0], 1'b0};
    q_o   <= {q_i[QB-2:0], fits};
    d_o   <= d_i;
    tag_o <= tag_i;
  end

endmodule

>>> rtl/pcp_div_chain.sv
// ----------------------------------------------------------------------------
// pcp_div_chain: row of division cells
// One cell per quotient bit; an item moves one cell along each cycle.
// ----------------------------------------------------------------------------
module pcp_div_chain import pcp_pkg::*; #(
  parameter int TW = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          vld_i,
  input  logic [RW-1:0] rem_i,
  input  logic [QB-1:0] num_i,
  input  logic [RW-1:0] d_i,
  input  logic [TW-1:0] tag_i,
  output logic          vld_o,
  output logic [QB-1:0] q_o,
  output logic [RW-1:0] rem_o,
  output logic [RW-1:0] d_o,
  output logic [TW-1:0] tag_o
);

  logic          vld [0:QB];
  logic [RW-1:0] rem [0:QB];
  logic [QB-1:0] num [0:QB];
  logic [QB-1:0] quo [0:QB];
  logic [RW-1:0] dv  [0:QB];
  logic [TW-1:0] tag [0:QB];

  assign vld[0] = vld_i;
  assign rem[0] = rem_i;
  assign num[0] = num_i;
  assign quo[0] = '0;
  assign dv[0]  = d_i;
  assign tag[0] = tag_i;

  for (genvar i = 0; i < QB; i++) begin : g_cell
    pcp_div_cell #(.TW(TW)) u_cell (
      .clk   (clk),
      .rst   (rst),
      .vld_i (vld[i]),
      .rem_i (rem[i]),
      .num_i (num[i]),
      .q_i   (quo[i]),
      .d_i   (dv[i]),
      .tag_i (tag[i]),
      .vld_o (vld[i+1]),
      .rem_o (rem[i+1]),
      .num_o (num[i+1]),
      .q_o   (quo[i+1]),
      .d_o   (dv[i+1]),
      .tag_o (tag[i+1])
    );
  end

  assign vld_o = vld[QB];
  assign q_o   = quo[QB];
  assign rem_o = rem[QB];
  assign d_o   = dv[QB];
  assign tag_o = tag[QB];

endmodule

>>> rtl/pcp_front.sv
// ----------------------------------------------------------------------------
// pcp_front: translate, rotate, near clip and numerator build
// Six register stages ending in the first remainder, numerator bits and
// divisor for each endpoint.
// ----------------------------------------------------------------------------
module pcp_front import pcp_pkg::*; #(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH,
  parameter int FRAC_BITS = DEF_FRAC_BITS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               vld_i,
  input  cfg_t               cfg,
  input  logic signed [31:0] ax_i,
  input  logic signed [31:0] ay_i,
  input  logic signed [31:0] bx_i,
  input  logic signed [31:0] by_i,
  input  logic               en_i,
  input  logic [COLW-1:0]    pmin_i,
  input  logic [COLW-1:0]    pmax_i,
  output logic               vld_o,
  output side_t              side_o,
  output logic               sign_a_o,
  output logic               sign_b_o,
  output logic [RW-1:0]      rem_a_o,
  output logic [RW-1:0]      rem_b_o,
  output logic [QB-1:0]      num_a_o,
  output logic [QB-1:0]      num_b_o,
  output logic [RW-1:0]      d_a_o,
  output logic [RW-1:0]      d_b_o
);

  localparam logic signed [CW-1:0] NEAR_Q = CW'(((1 << FRAC_BITS) + 5) / 10);

  logic [FRONT_DEPTH-1:0] vld_sr;
  side_t                  side [0:FRONT_DEPTH-1];
  side_t                  side_in;
  side_t                  side_nr;
  logic [WW-1:0]          width_c;

  // stage 0
  logic signed [32:0] s0_ax, s0_ay, s0_bx, s0_by;
  // stage 1
  logic signed [50:0] s1_p [0:7];
  // stage 2
  logic signed [51:0] sxa, sya, sxb, syb;
  logic signed [CW-1:0] s2_cxa, s2_cya, s2_cxb, s2_cyb;
  // stage 3
  logic signed [CW-1:0] neg_a, neg_b, cyc_a, cyc_b;
  logic                 near_a, near_b;
  logic [MAGW-1:0]      s3_mag_a, s3_mag_b;
  logic                 s3_sg_a, s3_sg_b;
  logic [RW-1:0]        s3_d_a, s3_d_b;
  // stage 4
  logic [48:0]          s4_lo_a, s4_lo_b;
  logic [47:0]          s4_hi_a, s4_hi_b;
  logic                 s4_sg_a, s4_sg_b;
  logic [RW-1:0]        s4_d_a, s4_d_b;
  // stage 5
  logic [NW-1:0]        n_a, n_b;

  // width limited to the largest screen
  assign width_c = ({19'b0, cfg.width} > 32'(MAX_WIDTH)) ? WW'(MAX_WIDTH) : cfg.width;

  always_comb begin
    side_in.inv   = ~en_i;
    side_in.width = width_c;
    side_in.pmin  = pmin_i;
    side_in.pmax  = pmax_i;
  end

  // both endpoints on or behind the near plane
  always_comb begin
    side_nr     = side[2];
    side_nr.inv = side[2].inv | (near_a & near_b);
  end

  // rotation sums, floor by arithmetic shift
  assign sxa = 52'(s1_p[0]) - 52'(s1_p[1]);
  assign sya = 52'(s1_p[2]) + 52'(s1_p[3]);
  assign sxb = 52'(s1_p[4]) - 52'(s1_p[5]);
  assign syb = 52'(s1_p[6]) + 52'(s1_p[7]);

  // near clip and magnitudes
  assign near_a = (s2_cya <= NEAR_Q);
  assign near_b = (s2_cyb <= NEAR_Q);
  assign cyc_a  = (s2_cya < NEAR_Q) ? NEAR_Q : s2_cya;
  assign cyc_b  = (s2_cyb < NEAR_Q) ? NEAR_Q : s2_cyb;
  assign neg_a  = -s2_cxa;
  assign neg_b  = -s2_cxb;

  // numerator from partial products
  assign n_a = NW'(s4_lo_a) + (NW'(s4_hi_a) << 18);
  assign n_b = NW'(s4_lo_b) + (NW'(s4_hi_b) << 18);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_sr <= '0;
    end else begin
      vld_sr <= {vld_sr[FRONT_DEPTH-2:0], vld_i};
    end
    side[0] <= side_in;
    for (int i = 1; i < FRONT_DEPTH; i++) begin
      side[i] <= (i == 3) ? side_nr : side[i-1];
    end

    s0_ax <= {ax_i[31], ax_i} - {cfg.cam_x[31], cfg.cam_x};
    s0_ay <= {ay_i[31], ay_i} - {cfg.cam_y[31], cfg.cam_y};
    s0_bx <= {bx_i[31], bx_i} - {cfg.cam_x[31], cfg.cam_x};
    s0_by <= {by_i[31], by_i} - {cfg.cam_y[31], cfg.cam_y};

    s1_p[0] <= s0_ax * $signed(cfg.cos_v);
    s1_p[1] <= s0_ay * $signed(cfg.sin_v);
    s1_p[2] <= s0_ax * $signed(cfg.sin_v);
    s1_p[3] <= s0_ay * $signed(cfg.cos_v);
    s1_p[4] <= s0_bx * $signed(cfg.cos_v);
    s1_p[5] <= s0_by * $signed(cfg.sin_v);
    s1_p[6] <= s0_bx * $signed(cfg.sin_v);
    s1_p[7] <= s0_by * $signed(cfg.cos_v);

    s2_cxa <= sxa[51:16];
    s2_cya <= sya[51:16];
    s2_cxb <= sxb[51:16];
    s2_cyb <= syb[51:16];

    s3_sg_a  <= s2_cxa[CW-1];
    s3_sg_b  <= s2_cxb[CW-1];
    s3_mag_a <= s2_cxa[CW-1] ? neg_a[MAGW-1:0] : s2_cxa[MAGW-1:0];
    s3_mag_b <= s2_cxb[CW-1] ? neg_b[MAGW-1:0] : s2_cxb[MAGW-1:0];
    s3_d_a   <= {{(RW-MAGW-16){1'b0}}, cyc_a[MAGW-1:0], 16'b0};
    s3_d_b   <= {{(RW-MAGW-16){1'b0}}, cyc_b[MAGW-1:0], 16'b0};

    s4_lo_a <= s3_mag_a[17:0] * cfg.focal;
    s4_hi_a <= s3_mag_a[MAGW-1:18] * cfg.focal;
    s4_lo_b <= s3_mag_b[17:0] * cfg.focal;
    s4_hi_b <= s3_mag_b[MAGW-1:18] * cfg.focal;
    s4_sg_a <= s3_sg_a;
    s4_sg_b <= s3_sg_b;
    s4_d_a  <= s3_d_a;
    s4_d_b  <= s3_d_b;

    rem_a_o  <= RW'(n_a[NW-1:QB]);
    rem_b_o  <= RW'(n_b[NW-1:QB]);
    num_a_o  <= n_a[QB-1:0];
    num_b_o  <= n_b[QB-1:0];
    d_a_o    <= s4_d_a;
    d_b_o    <= s4_d_b;
    sign_a_o <= s4_sg_a;
    sign_b_o <= s4_sg_b;
  end

  assign vld_o  = vld_sr[FRONT_DEPTH-1];
  assign side_o = side[FRONT_DEPTH-1];

endmodule

>>> rtl/pcp_checker.sv
// ----------------------------------------------------------------------------
// pcp_checker: port level checks for the portal column projection
// Fixed latency between item and result, and consistency of the results.
// ----------------------------------------------------------------------------
module pcp_checker import pcp_pkg::*; (
  input logic            clk,
  input logic            rst,
  input logic            start,
  input logic            busy,
  input logic            done,
  input logic            visible,
  input logic [COLW-1:0] col_min,
  input logic [COLW-1:0] col_max
);

  // every accepted item gives a result at the end of the pipeline
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##PIPE_DEPTH done)
    else $error("result missing after item");

  // no result without an item
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, PIPE_DEPTH))
    else $error("result without item");

  // a visible range is ordered
  a_ordered: assert property (@(posedge clk) disable iff (rst)
    (done && visible) |-> (col_min <= col_max))
    else $error("column range reversed");

  // invisible results carry zero columns
  a_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !visible) |-> (col_min == '0 && col_max == '0))
    else $error("invisible result with columns");

endmodule

bind portal_column_projection pcp_checker u_pcp_checker (
  .clk     (clk),
  .rst     (rst),
  .start   (start),
  .busy    (busy),
  .done    (done),
  .visible (visible),
  .col_min (col_min),
  .col_max (col_max)
);
